### hw/rtl/bma_pkg.sv
// shared types and constants for the buddy allocator
package bma_pkg;

  localparam int COUNT_W = 17;
  localparam int ADDR_W  = 48;
  localparam int REQ_W   = 32;
  localparam int NEED_W  = 33;
  localparam int OFF_W   = 32;
  localparam int WANT_W  = 6;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // classified word handed from the front to the engine
  typedef struct packed {
    logic                is_free;
    logic                bad;
    logic [NEED_W-1:0]   need;
    logic [WANT_W-1:0]   want;
    logic [OFF_W-1:0]    off;
  } bma_cmd_t;

endpackage

### hw/rtl/bma_front.sv
// front stage: accepts input words and classifies them into engine commands
module bma_front #(
  parameter int LOG2_TOTAL_BYTES = 16,
  parameter int HEADER_BYTES     = 16,
  parameter int LOG2_MIN_BLOCK   = 5
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [79:0]                  in_tdata,
  input  logic                         in_tuser,
  input  logic [bma_pkg::ADDR_W-1:0]   base_addr,
  output logic                         cmd_valid,
  input  logic                         cmd_ready,
  output bma_pkg::bma_cmd_t            cmd
);

  localparam logic [bma_pkg::ADDR_W-1:0] REGION =
    bma_pkg::ADDR_W'(1) << LOG2_TOTAL_BYTES;

  logic                          valid_r;
  bma_pkg::bma_cmd_t             cmd_r;
  bma_pkg::bma_cmd_t             cmd_nxt;
  logic [bma_pkg::REQ_W-1:0]     req;
  logic [bma_pkg::ADDR_W-1:0]    addr;
  logic [bma_pkg::ADDR_W-1:0]    pay;
  logic                          bad_free;

  assign req       = in_tdata[31:0];
  assign addr      = in_tdata[79:32];
  assign in_tready = !valid_r || cmd_ready;
  assign cmd_valid = valid_r;
  assign cmd       = cmd_r;

  always_comb begin
    pay      = addr - base_addr;
    bad_free = (addr == '0) || (addr < base_addr) || (pay >= REGION) ||
               (pay < bma_pkg::ADDR_W'(HEADER_BYTES));
    cmd_nxt.is_free = (in_tuser == bma_pkg::KIND_FREE);
    cmd_nxt.need    = bma_pkg::NEED_W'(req) + bma_pkg::NEED_W'(HEADER_BYTES);
    cmd_nxt.off     = bma_pkg::OFF_W'(pay - bma_pkg::ADDR_W'(HEADER_BYTES));
    cmd_nxt.bad     = cmd_nxt.is_free ? bad_free : (req == '0);
    // smallest power of two, no smaller than the minimum block, that holds request plus header
    cmd_nxt.want    = bma_pkg::WANT_W'(33);
    for (int w = 32; w >= LOG2_MIN_BLOCK; w--) begin
      if ((bma_pkg::NEED_W'(1) << w) >= cmd_nxt.need) begin
        cmd_nxt.want = bma_pkg::WANT_W'(w);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      cmd_r <= cmd_nxt;
    end
  end

endmodule

### hw/rtl/bma_fifo.sv
// two-entry command queue between front and engine
module bma_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  bma_pkg::bma_cmd_t push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output bma_pkg::bma_cmd_t pop_data
);

  bma_pkg::bma_cmd_t mem_r [2];
  logic              wr_ptr_r;
  logic              rd_ptr_r;
  logic [1:0]        count_r;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= !wr_ptr_r;
      if (do_pop)  rd_ptr_r <= !rd_ptr_r;
      if (do_push && !do_pop)      count_r <= count_r + 2'd1;
      else if (do_pop && !do_push) count_r <= count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### hw/rtl/bma_engine.sv
// back end: scans, splits and merges the block tree and holds the result register
module bma_engine #(
  parameter int LOG2_TOTAL_BYTES = 16,
  parameter int LEVEL_COUNT      = 17,
  parameter int HEADER_BYTES     = 16,
  parameter int LOG2_MIN_BLOCK   = 5
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cmd_valid,
  output logic                            cmd_ready,
  input  bma_pkg::bma_cmd_t               cmd,
  input  logic [bma_pkg::ADDR_W-1:0]      base_addr,
  output logic                            res_valid,
  input  logic                            res_ready,
  output logic                            res_ok,
  output logic [bma_pkg::ADDR_W-1:0]      res_grant,
  output logic [bma_pkg::COUNT_W-1:0]     res_size,
  output logic [bma_pkg::COUNT_W-1:0]     res_free,
  output logic [bma_pkg::COUNT_W-1:0]     res_used
);

  localparam int T      = LOG2_TOTAL_BYTES;
  localparam int SPAN   = LOG2_TOTAL_BYTES - LOG2_MIN_BLOCK;
  localparam int NODES  = (2 << SPAN) - 1;
  localparam int NW     = SPAN + 1;
  localparam int SLOTS  = 1 << SPAN;
  localparam int SW     = (SPAN < 1) ? 1 : SPAN;
  localparam int LVW    = $clog2(LOG2_TOTAL_BYTES + 1);
  localparam int MAXLV  = (LOG2_TOTAL_BYTES < LEVEL_COUNT - 1) ?
                          LOG2_TOTAL_BYTES : LEVEL_COUNT - 1;
  localparam int CW     = bma_pkg::COUNT_W;
  localparam logic [CW-1:0] FREE_RESET =
    (LOG2_TOTAL_BYTES < CW) ? (CW'(1) << LOG2_TOTAL_BYTES) : '0;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_CHECK, S_SCAN, S_SCAN_CHK, S_SPLIT,
    S_FREE_RD, S_FREE_CHK, S_MERGE, S_MERGE_CHK
  } state_t;

  state_t                    state_r;
  bma_pkg::bma_cmd_t         cmd_r;
  logic [T-1:0]              off_r;
  logic [LVW-1:0]            lv_r;
  logic [NW-1:0]             node_r;
  logic [NW-1:0]             clr_r;
  logic [CW-1:0]             free_cnt_r;
  logic [CW-1:0]             used_cnt_r;
  logic [CW-1:0]             rel_r;
  logic                      out_valid_r;
  logic                      out_ok_r;
  logic [bma_pkg::ADDR_W-1:0] out_grant_r;
  logic [CW-1:0]             out_size_r;

  logic                      map_mem [NODES];
  logic                      map_rdata_r;
  logic [NW-1:0]             map_raddr;
  logic                      map_we;
  logic [NW-1:0]             map_waddr;
  logic                      map_wdata;

  logic [LVW-1:0]            lvl_mem [SLOTS];
  logic [LVW-1:0]            lvl_rdata_r;
  logic                      lvl_we;
  logic [SW-1:0]             slot;

  logic [LVW-1:0]            want_lv;
  logic [T-1:0]              buddy_off;
  logic [T:0]                align_mask;
  logic                      lv_bad;

  function automatic logic [NW-1:0] first_node(input logic [LVW-1:0] lv);
    logic [NW:0] one;
    one = (NW+1)'(1);
    return NW'((one << (T - int'(lv))) - one);
  endfunction

  function automatic logic [NW-1:0] node_of(input logic [LVW-1:0] lv,
                                             input logic [T-1:0] off);
    return first_node(lv) + NW'(off >> lv);
  endfunction

  function automatic logic [CW-1:0] size_of(input logic [LVW-1:0] lv);
    return (int'(lv) < CW) ? (CW'(1) << lv) : '0;
  endfunction

  assign cmd_ready = (state_r == S_IDLE) && !out_valid_r;
  assign res_valid = out_valid_r;
  assign res_ok    = out_ok_r;
  assign res_grant = out_grant_r;
  assign res_size  = out_size_r;
  assign res_free  = free_cnt_r;
  assign res_used  = used_cnt_r;

  assign want_lv    = LVW'(cmd_r.want);
  assign slot       = SW'(off_r >> LOG2_MIN_BLOCK);
  assign buddy_off  = off_r ^ T'(size_of(lv_r) | CW'(0)) ^ T'(0);
  assign align_mask = ((T+1)'(1) << lvl_rdata_r) - (T+1)'(1);
  assign lv_bad     = (int'(lvl_rdata_r) < LOG2_MIN_BLOCK) || (int'(lvl_rdata_r) > T) ||
                      (({1'b0, off_r} & align_mask) != '0);

  // memory port decode
  always_comb begin
    map_raddr = node_r;
    map_we    = 1'b0;
    map_waddr = node_r;
    map_wdata = 1'b0;
    lvl_we    = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        map_we    = 1'b1;
        map_waddr = clr_r;
        map_wdata = (clr_r == '0);
      end
      S_SCAN_CHK: begin
        map_we    = map_rdata_r;
        map_waddr = node_r;
      end
      S_SPLIT: begin
        if (lv_r > want_lv) begin
          map_we    = 1'b1;
          map_waddr = node_of(lv_r - LVW'(1), off_r + (T'(1) << (lv_r - LVW'(1))));
          map_wdata = 1'b1;
        end else begin
          lvl_we = 1'b1;
        end
      end
      S_MERGE: begin
        map_raddr = node_of(lv_r, buddy_off);
        if (int'(lv_r) >= T) begin
          map_we    = 1'b1;
          map_waddr = node_of(lv_r, off_r);
          map_wdata = 1'b1;
        end
      end
      S_MERGE_CHK: begin
        map_we = 1'b1;
        if (map_rdata_r) begin
          map_waddr = node_of(lv_r, buddy_off);
          map_wdata = 1'b0;
        end else begin
          map_waddr = node_of(lv_r, off_r);
          map_wdata = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (map_we) map_mem[map_waddr] <= map_wdata;
    map_rdata_r <= map_mem[map_raddr];
  end

  always_ff @(posedge clk) begin
    if (lvl_we) lvl_mem[slot] <= want_lv;
    lvl_rdata_r <= lvl_mem[slot];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      free_cnt_r  <= FREE_RESET;
      used_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && res_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + NW'(1);
          if (clr_r == NW'(NODES - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (cmd_valid && !out_valid_r) begin
            cmd_r   <= cmd;
            off_r   <= T'(cmd.off);
            state_r <= cmd.is_free ? S_FREE_RD : S_CHECK;
          end
        end
        S_CHECK: begin
          if (cmd_r.bad || (cmd_r.need > bma_pkg::NEED_W'(free_cnt_r)) ||
              (int'(cmd_r.want) > MAXLV)) begin
            out_valid_r <= 1'b1;
            out_ok_r    <= 1'b0;
            out_grant_r <= '0;
            out_size_r  <= '0;
            state_r     <= S_IDLE;
          end else begin
            lv_r    <= want_lv;
            node_r  <= first_node(want_lv);
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          state_r <= S_SCAN_CHK;
        end
        S_SCAN_CHK: begin
          if (map_rdata_r) begin
            off_r   <= T'(node_r - first_node(lv_r)) << lv_r;
            state_r <= S_SPLIT;
          end else if (node_r == first_node(lv_r) + first_node(lv_r)) begin
            // last node of this level
            if (int'(lv_r) >= MAXLV) begin
              out_valid_r <= 1'b1;
              out_ok_r    <= 1'b0;
              out_grant_r <= '0;
              out_size_r  <= '0;
              state_r     <= S_IDLE;
            end else begin
              lv_r    <= lv_r + LVW'(1);
              node_r  <= first_node(lv_r + LVW'(1));
              state_r <= S_SCAN;
            end
          end else begin
            node_r  <= node_r + NW'(1);
            state_r <= S_SCAN;
          end
        end
        S_SPLIT: begin
          if (lv_r > want_lv) begin
            lv_r <= lv_r - LVW'(1);
          end else begin
            free_cnt_r  <= free_cnt_r - size_of(want_lv);
            used_cnt_r  <= used_cnt_r + size_of(want_lv);
            out_valid_r <= 1'b1;
            out_ok_r    <= 1'b1;
            out_grant_r <= base_addr + bma_pkg::ADDR_W'(off_r) +
                           bma_pkg::ADDR_W'(HEADER_BYTES);
            out_size_r  <= size_of(want_lv);
            state_r     <= S_IDLE;
          end
        end
        S_FREE_RD: begin
          if (cmd_r.bad) begin
            out_valid_r <= 1'b1;
            out_ok_r    <= 1'b0;
            out_grant_r <= '0;
            out_size_r  <= '0;
            state_r     <= S_IDLE;
          end else begin
            state_r <= S_FREE_CHK;
          end
        end
        S_FREE_CHK: begin
          if (lv_bad) begin
            out_valid_r <= 1'b1;
            out_ok_r    <= 1'b0;
            out_grant_r <= '0;
            out_size_r  <= '0;
            state_r     <= S_IDLE;
          end else begin
            lv_r    <= lvl_rdata_r;
            rel_r   <= size_of(lvl_rdata_r);
            state_r <= S_MERGE;
          end
        end
        S_MERGE: begin
          state_r <= (int'(lv_r) >= T) ? S_IDLE : S_MERGE_CHK;
          if (int'(lv_r) >= T) begin
            free_cnt_r  <= free_cnt_r + rel_r;
            used_cnt_r  <= used_cnt_r - rel_r;
            out_valid_r <= 1'b1;
            out_ok_r    <= 1'b1;
            out_grant_r <= '0;
            out_size_r  <= rel_r;
          end
        end
        S_MERGE_CHK: begin
          if (map_rdata_r) begin
            // buddy is free: absorb it and climb one level
            off_r   <= off_r & ~buddy_off ^ (off_r & ~buddy_off) ^ (off_r & buddy_off);
            lv_r    <= lv_r + LVW'(1);
            state_r <= S_MERGE;
          end else begin
            free_cnt_r  <= free_cnt_r + rel_r;
            used_cnt_r  <= used_cnt_r - rel_r;
            out_valid_r <= 1'b1;
            out_ok_r    <= 1'b1;
            out_grant_r <= '0;
            out_size_r  <= rel_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

### hw/rtl/buddy_memory_allocator_top.sv
// Binary buddy allocator over a 2^LOG2_TOTAL_BYTES byte region at base_address.
// Input channel in_*: one word per request. in_tuser is the kind (0 allocate,
// 1 free); in_tdata carries request_bytes then free_address.
// Output channel out_*: exactly one result word per request, in order.
// out_tuser is ok; out_tdata carries grant_address, granted_block_bytes,
// free_bytes and used_bytes.
// cfg_we/cfg_wdata write base_address; write it only while the block is idle.
// Requests pass the front stage and a two-entry queue, then the engine, which
// takes one request at a time. An allocate scans the free map level by level,
// one node at a time through its single read port, then splits the block it
// finds down to the wanted level. A free looks up the block's level, then merges it with each free buddy.
// After reset the engine sweeps the free map, all 2^(LOG2_TOTAL_BYTES -
// LOG2_MIN_BLOCK + 1) - 1 nodes (4095 by default), before it takes a request.
// While out_tready is low the result is held; the engine waits with the next
// request, and the front and queue keep accepting up to three more words.
module buddy_memory_allocator_top #(
  parameter int LOG2_TOTAL_BYTES = 16,
  parameter int LEVEL_COUNT      = 17,
  parameter int HEADER_BYTES     = 16,
  parameter int LOG2_MIN_BLOCK   = 5
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [79:0]  in_tdata,   // request_bytes[31:0], free_address[79:32]
  input  logic         in_tuser,   // kind
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata,  // grant_address, granted_block_bytes, free_bytes, used_bytes, zero fill
  output logic         out_tuser,  // ok
  input  logic         cfg_we,
  input  logic [47:0]  cfg_wdata
);

  logic [bma_pkg::ADDR_W-1:0]  base_r;
  logic                        f_valid;
  logic                        f_ready;
  bma_pkg::bma_cmd_t           f_cmd;
  logic                        q_valid;
  logic                        q_ready;
  bma_pkg::bma_cmd_t           q_cmd;
  logic [bma_pkg::ADDR_W-1:0]  grant;
  logic [bma_pkg::COUNT_W-1:0] blk_size;
  logic [bma_pkg::COUNT_W-1:0] free_cnt;
  logic [bma_pkg::COUNT_W-1:0] used_cnt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
    end else if (cfg_we) begin
      base_r <= cfg_wdata;
    end
  end

  bma_front #(
    .LOG2_TOTAL_BYTES(LOG2_TOTAL_BYTES),
    .HEADER_BYTES(HEADER_BYTES),
    .LOG2_MIN_BLOCK(LOG2_MIN_BLOCK)
  ) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .base_addr(base_r),
    .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
  );

  bma_fifo u_fifo (
    .clk(clk), .rst_n(rst_n),
    .push_valid(f_valid), .push_ready(f_ready), .push_data(f_cmd),
    .pop_valid(q_valid), .pop_ready(q_ready), .pop_data(q_cmd)
  );

  bma_engine #(
    .LOG2_TOTAL_BYTES(LOG2_TOTAL_BYTES),
    .LEVEL_COUNT(LEVEL_COUNT),
    .HEADER_BYTES(HEADER_BYTES),
    .LOG2_MIN_BLOCK(LOG2_MIN_BLOCK)
  ) u_engine (
    .clk(clk), .rst_n(rst_n),
    .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
    .base_addr(base_r),
    .res_valid(out_tvalid), .res_ready(out_tready),
    .res_ok(out_tuser), .res_grant(grant), .res_size(blk_size),
    .res_free(free_cnt), .res_used(used_cnt)
  );

  assign out_tdata = {5'b0, used_cnt, free_cnt, blk_size, grant};

endmodule

### hw/rtl/bma_checker.sv
// port-level checks for the buddy allocator, bound to the top level
module bma_checker #(
  parameter int LOG2_TOTAL_BYTES = 16
) (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [103:0] out_tdata,
  input logic         out_tuser
);

  localparam logic [16:0] TOTAL =
    (LOG2_TOTAL_BYTES < 17) ? (17'(1) << LOG2_TOTAL_BYTES) : '0;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped or changed while stalled");

  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[64:0] == '0)
    else $error("refused word carries an address or size");

  a_balance: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> 17'(out_tdata[81:65] + out_tdata[98:82]) == TOTAL)
    else $error("free and used bytes do not add up to the region");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind buddy_memory_allocator_top bma_checker #(
  .LOG2_TOTAL_BYTES(LOG2_TOTAL_BYTES)
) u_bma_checker (.*);
